/* design/mlm_pkg.sv */
package mlm_pkg;

    // Default sizes
    localparam int DEF_MAX_LOCKS   = 64;
    localparam int DEF_MAX_WAITERS = 256;

    // Fixed field widths
    localparam int FUNC_W   = 2;
    localparam int ID_W     = 31;
    localparam int LOCK_W   = 6;
    localparam int STATUS_W = 2;

    // Request kinds
    localparam logic [FUNC_W-1:0] FUNC_CREATE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_LOCK   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_LOCK  = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   requester;
        logic [LOCK_W-1:0] lock_id;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]     wake_id;
        logic [LOCK_W-1:0]   lock_number;
        logic [STATUS_W-1:0] status;
        logic                last;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LREAD,
        S_WALK,
        S_PUSH,
        S_RREL,
        S_OUT_FIRST,
        S_OUT
    } state_t;

    // What goes into the lock table entry
    typedef enum logic [2:0] {
        LW_CREATE,
        LW_TAKE,
        LW_PUSH,
        LW_FREE,
        LW_POP
    } lwsel_t;

    // Waiter table read address source
    typedef enum logic {
        WRD_HEAD,
        WRD_NEXT
    } wrsel_t;

    // Result register source
    typedef enum logic [1:0] {
        RES_REQ,
        RES_NEW,
        RES_NONE_LEFT,
        RES_WAKE2
    } ressrc_t;

    typedef struct packed {
        logic                latch_req;
        logic                lock_rd;
        logic                lock_wr;
        lwsel_t              lock_wr_sel;
        logic                inc_locks;
        logic                wait_rd;
        wrsel_t              wait_rd_sel;
        logic                cap_head;
        logic                cap_wake2;
        logic                push;
        logic                res_set;
        ressrc_t             res_src;
        logic [STATUS_W-1:0] res_status;
        logic                res_last;
        logic                out_load;
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              lock_bad;
        logic              locks_full;
        logic              pool_full;
        logic              lock_free;
        logic              head_empty;
        logic              node_match;
        logic              next_empty;
        logic              out_free;
    } stat_t;

endpackage

/* design/mlm_ram.sv */
module mlm_ram
    import mlm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/mlm_ctrl.sv */
module mlm_ctrl
    import mlm_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.lock_wr_sel = LW_FREE;
        cmd.wait_rd_sel = WRD_HEAD;
        cmd.res_src     = RES_REQ;
        cmd.res_status  = ST_OK;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_DECODE;
                end
            end

            S_DECODE: begin
                cmd.lock_rd = 1'b1;
                case (stat.func)
                    FUNC_CREATE: begin
                        cmd.res_set  = 1'b1;
                        cmd.res_last = 1'b1;
                        if (stat.locks_full) begin
                            cmd.res_src    = RES_NONE_LEFT;
                            cmd.res_status = ST_NO_LOCK;
                        end else begin
                            cmd.lock_wr     = 1'b1;
                            cmd.lock_wr_sel = LW_CREATE;
                            cmd.inc_locks   = 1'b1;
                            cmd.res_src     = RES_NEW;
                        end
                        state_next = S_OUT;
                    end
                    FUNC_ACQUIRE, FUNC_RELEASE: begin
                        if (stat.lock_bad) begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = ST_BAD_LOCK;
                            cmd.res_last   = 1'b1;
                            state_next     = S_OUT;
                        end else begin
                            state_next = S_LREAD;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_LREAD: begin
                cmd.cap_head = 1'b1;
                if (stat.func == FUNC_ACQUIRE) begin
                    if (stat.lock_free) begin
                        cmd.lock_wr     = 1'b1;
                        cmd.lock_wr_sel = LW_TAKE;
                        cmd.res_set     = 1'b1;
                        cmd.res_last    = 1'b1;
                        state_next      = S_OUT;
                    end else if (stat.head_empty) begin
                        state_next = S_PUSH;
                    end else begin
                        cmd.wait_rd = 1'b1;
                        state_next  = S_WALK;
                    end
                end else begin
                    if (stat.head_empty) begin
                        cmd.lock_wr  = 1'b1;
                        cmd.res_set  = 1'b1;
                        cmd.res_last = 1'b1;
                        state_next   = S_OUT;
                    end else begin
                        cmd.wait_rd = 1'b1;
                        state_next  = S_RREL;
                    end
                end
            end

            S_WALK: begin
                if (stat.node_match) begin
                    state_next = S_IDLE;
                end else if (stat.next_empty) begin
                    state_next = S_PUSH;
                end else begin
                    cmd.wait_rd     = 1'b1;
                    cmd.wait_rd_sel = WRD_NEXT;
                end
            end

            S_PUSH: begin
                if (stat.pool_full) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_POOL_FULL;
                    cmd.res_last   = 1'b1;
                    state_next     = S_OUT;
                end else begin
                    cmd.push        = 1'b1;
                    cmd.lock_wr     = 1'b1;
                    cmd.lock_wr_sel = LW_PUSH;
                    state_next      = S_IDLE;
                end
            end

            S_RREL: begin
                cmd.cap_wake2   = 1'b1;
                cmd.lock_wr     = 1'b1;
                cmd.lock_wr_sel = LW_POP;
                cmd.res_set     = 1'b1;
                state_next      = S_OUT_FIRST;
            end

            S_OUT_FIRST: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.res_set  = 1'b1;
                    cmd.res_src  = RES_WAKE2;
                    cmd.res_last = 1'b1;
                    state_next   = S_OUT;
                end
            end

            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* design/mlm_dpath.sv */
module mlm_dpath
    import mlm_pkg::*;
#(
    parameter int MAX_LOCKS   = DEF_MAX_LOCKS,
    parameter int MAX_WAITERS = DEF_MAX_WAITERS
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  req_t  s_data,
    output logic  m_valid,
    input  logic  m_ready,
    output rsp_t  m_data,
    input  cmd_t  cmd,
    output stat_t stat
);

    localparam int LAW  = $clog2(MAX_LOCKS);
    localparam int LCW  = $clog2(MAX_LOCKS + 1);
    localparam int PW   = $clog2(MAX_WAITERS);
    localparam int NW   = $clog2(MAX_WAITERS + 1);
    localparam int CMPW = (LCW > LOCK_W) ? LCW : LOCK_W;
    localparam int LEW  = 1 + NW;
    localparam int WEW  = ID_W + NW;
    localparam logic [NW-1:0] EMPTY = NW'(MAX_WAITERS);

    req_t          req_reg;
    logic [LCW-1:0] locks_alloc_reg;
    logic [NW-1:0]  nodes_alloc_reg;
    logic [NW-1:0]  head_reg;
    logic [ID_W-1:0] wake2_reg;
    rsp_t          res_reg;
    logic          out_valid_reg;
    rsp_t          out_data_reg;

    logic [LAW-1:0] lock_addr;
    logic [LAW-1:0] lock_wr_addr;
    logic [LEW-1:0] lock_wr_data;
    logic [LEW-1:0] lock_rd_data;
    logic           lock_rd_free;
    logic [NW-1:0]  lock_rd_head;

    logic [PW-1:0]  wait_rd_addr;
    logic [WEW-1:0] wait_rd_data;
    logic [ID_W-1:0] wait_rd_id;
    logic [NW-1:0]  wait_rd_next;
    logic           out_free;

    assign lock_addr    = LAW'(req_reg.lock_id);
    assign lock_rd_free = lock_rd_data[NW];
    assign lock_rd_head = lock_rd_data[NW-1:0];
    assign wait_rd_id   = wait_rd_data[WEW-1:NW];
    assign wait_rd_next = wait_rd_data[NW-1:0];
    assign out_free     = !out_valid_reg || m_ready;

    // Lock table: free flag and waiter list head, one entry per lock
    always_comb begin
        lock_wr_addr = (cmd.lock_wr_sel == LW_CREATE) ? locks_alloc_reg[LAW-1:0] : lock_addr;
        case (cmd.lock_wr_sel)
            LW_CREATE: lock_wr_data = {1'b1, EMPTY};
            LW_TAKE:   lock_wr_data = {1'b0, lock_rd_head};
            LW_PUSH:   lock_wr_data = {1'b0, nodes_alloc_reg};
            LW_POP:    lock_wr_data = {1'b0, wait_rd_next};
            default:   lock_wr_data = {1'b1, EMPTY};
        endcase
    end

    mlm_ram #(
        .WIDTH(LEW),
        .DEPTH(MAX_LOCKS)
    ) u_lock_ram (
        .aclk    (aclk),
        .wr_en   (cmd.lock_wr),
        .wr_addr (lock_wr_addr),
        .wr_data (lock_wr_data),
        .rd_en   (cmd.lock_rd),
        .rd_addr (lock_addr),
        .rd_data (lock_rd_data)
    );

    // Waiter node pool
    assign wait_rd_addr = (cmd.wait_rd_sel == WRD_NEXT) ? wait_rd_next[PW-1:0]
                                                        : lock_rd_head[PW-1:0];

    mlm_ram #(
        .WIDTH(WEW),
        .DEPTH(MAX_WAITERS)
    ) u_wait_ram (
        .aclk    (aclk),
        .wr_en   (cmd.push),
        .wr_addr (nodes_alloc_reg[PW-1:0]),
        .wr_data ({req_reg.requester, head_reg}),
        .rd_en   (cmd.wait_rd),
        .rd_addr (wait_rd_addr),
        .rd_data (wait_rd_data)
    );

    // Control counters and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            locks_alloc_reg <= '0;
            nodes_alloc_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cmd.inc_locks) begin
                locks_alloc_reg <= locks_alloc_reg + LCW'(1);
            end
            if (cmd.push) begin
                nodes_alloc_reg <= nodes_alloc_reg + NW'(1);
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.latch_req) begin
            req_reg <= s_data;
        end
        if (cmd.cap_head) begin
            head_reg <= lock_rd_head;
        end
        if (cmd.cap_wake2) begin
            wake2_reg <= wait_rd_id;
        end
        if (cmd.res_set) begin
            res_reg.status <= cmd.res_status;
            res_reg.last   <= cmd.res_last;
            case (cmd.res_src)
                RES_NEW: begin
                    res_reg.wake_id     <= req_reg.requester;
                    res_reg.lock_number <= LOCK_W'(locks_alloc_reg);
                end
                RES_NONE_LEFT: begin
                    res_reg.wake_id     <= req_reg.requester;
                    res_reg.lock_number <= '0;
                end
                RES_WAKE2: begin
                    res_reg.wake_id     <= wake2_reg;
                    res_reg.lock_number <= req_reg.lock_id;
                end
                default: begin
                    res_reg.wake_id     <= req_reg.requester;
                    res_reg.lock_number <= req_reg.lock_id;
                end
            endcase
        end
        if (cmd.out_load) begin
            out_data_reg <= res_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        stat.func       = req_reg.func;
        stat.lock_bad   = CMPW'(req_reg.lock_id) >= CMPW'(locks_alloc_reg);
        stat.locks_full = locks_alloc_reg == LCW'(MAX_LOCKS);
        stat.pool_full  = nodes_alloc_reg == NW'(MAX_WAITERS);
        stat.lock_free  = lock_rd_free;
        stat.head_empty = lock_rd_head >= EMPTY;
        stat.node_match = wait_rd_id == req_reg.requester;
        stat.next_empty = wait_rd_next >= EMPTY;
        stat.out_free   = out_free;
    end

endmodule

/* design/mutex_lock_manager_with_waiters.sv */
// Mutex manager with per-lock LIFO waiter lists.
// Input channel (s_valid/s_ready/s_data): one request item, create, acquire
// or release, with requester id and lock id. Result channel (m_valid/m_ready/
// m_data): zero, one or two result items per request; last marks the final one.
// One request is in work at a time; s_ready is high only while the sequencer
// is idle. Results are formed in the decode step for a create or a bad lock
// id, in the lock read step for an acquire of a free lock or a release with
// no waiters, and in the push step, after the waiter list walk (one list node
// per cycle through the waiter RAM read port), for a pool-full answer to an
// acquire of a busy lock; a release with waiters forms its two in turn. The
// next request is taken in the cycle after the last result is loaded, or
// right after an acquire that only queues its requester.
// Results sit in a one-item output register: while the receiver stalls the
// block may still accept the next request and work on it up to its first
// result. Synchronous reset (aresetn low) empties the output register and
// clears the lock and node counters; the lock table needs no clearing since
// only entries of created locks are ever used, and create initializes them.
module mutex_lock_manager_with_waiters
    import mlm_pkg::*;
#(
    parameter int MAX_LOCKS   = DEF_MAX_LOCKS,
    parameter int MAX_WAITERS = DEF_MAX_WAITERS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    cmd_t  cmd;   // sequencer -> datapath
    stat_t stat;  // datapath -> sequencer

    // Sequencer: walks create / acquire / release through their steps
    mlm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: lock table RAM, waiter pool RAM, counters, result registers
    mlm_dpath #(
        .MAX_LOCKS   (MAX_LOCKS),
        .MAX_WAITERS (MAX_WAITERS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

/* design/mlm_checker.sv */
module mlm_checker
    import mlm_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input req_t s_data,
    input logic m_valid,
    input logic m_ready,
    input rsp_t m_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // only a release answer can be non-final, and it is always ok
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> m_data.status == ST_OK)
        else $error("non-final result with error status");

    // one request in work at a time
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind mutex_lock_manager_with_waiters mlm_checker u_mlm_checker (.*);
